FILE: rtl/core/expression_token_lexer_defines.svh
// Assertion helpers for the lexer
`ifndef EXPRESSION_TOKEN_LEXER_DEFINES_SVH
`define EXPRESSION_TOKEN_LEXER_DEFINES_SVH

// same-cycle implication
`define ETL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ETL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/etl_pkg.sv
package etl_pkg;

    localparam int VALUE_BITS = 32;
    localparam int BUF_DEPTH  = 4;
    localparam int BUF_AW     = $clog2(BUF_DEPTH);

    localparam logic [7:0] MAX_IDENT_RST = 8'd32;
    localparam logic [2:0] KW_LEN        = 3'd5;

    localparam logic [3:0] TOK_PLUS       = 4'd0;
    localparam logic [3:0] TOK_MINUS      = 4'd1;
    localparam logic [3:0] TOK_STAR       = 4'd2;
    localparam logic [3:0] TOK_EXP        = 4'd3;
    localparam logic [3:0] TOK_SLASH      = 4'd4;
    localparam logic [3:0] TOK_SEMI       = 4'd5;
    localparam logic [3:0] TOK_INT        = 4'd6;
    localparam logic [3:0] TOK_PRINT      = 4'd7;
    localparam logic [3:0] TOK_END        = 4'd8;
    localparam logic [3:0] TOK_BAD_IDENT  = 4'd9;
    localparam logic [3:0] TOK_LONG_IDENT = 4'd10;
    localparam logic [3:0] TOK_BAD_CHAR   = 4'd11;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_UND   = 8'h5F;

    typedef struct packed {
        logic [3:0]  token;
        logic [31:0] value;
        logic [31:0] line;
        logic        last;
    } t_result;

    // keyword text "print"
    function automatic logic [7:0] etl_kw_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h70;
            3'd1:    ch = 8'h72;
            3'd2:    ch = 8'h69;
            3'd3:    ch = 8'h6E;
            3'd4:    ch = 8'h74;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic etl_is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic etl_is_head(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               (c == CH_UND) || (c == CH_DOLLAR);
    endfunction

    function automatic logic etl_is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) ||
               (c == CH_FF);
    endfunction

endpackage

FILE: rtl/core/expression_token_lexer.sv
// Streaming tokenizer: one source byte (or end-of-input mark) is taken per transfer,
// and each input is scanned in the cycle it is accepted. Up to two tokens per input
// are written into a 4-entry result buffer, which drains one token per cycle while
// i_m_tready is high, so the sustained rate is one input per cycle as long as
// inputs average at most one token; the input side holds off (tready low) while
// fewer than two free buffer slots remain. An error token halts the scanner: later
// inputs are accepted and dropped until reset. Tokens are registered in the buffer.
module expression_token_lexer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config: max_ident_length
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] ch
    input  logic        i_s_tuser,   // kind: 0 byte, 1 end of input
    // token stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // [3:0] token, [35:4] value, [67:36] line, rest 0
    output logic        o_m_tlast    // last token of its input
);
    import etl_pkg::*;

`include "expression_token_lexer_defines.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_STAR,
        S_INT,
        S_IDENT
    } t_mode;

    typedef struct packed {
        t_mode                 mode;
        logic [VALUE_BITS-1:0] acc;
        logic [7:0]            icnt;
        logic [2:0]            kprog;
        logic                  kposs;
        logic                  halt;
    } t_scan;

    typedef struct packed {
        t_scan       s;
        logic        emit;
        logic [3:0]  tok;
        logic [31:0] val;
    } t_step;

    // scan a byte from the between-tokens state
    function automatic t_step f_idle(input logic [7:0] c, input logic [7:0] limit,
                                     input t_scan cur);
        t_step r;
        r      = '0;
        r.s    = cur;
        r.s.mode = S_IDLE;
        if (etl_is_space(c)) begin
            r.emit = 1'b0;
        end else if (c == CH_PLUS) begin
            r.emit = 1'b1;
            r.tok  = TOK_PLUS;
        end else if (c == CH_MINUS) begin
            r.emit = 1'b1;
            r.tok  = TOK_MINUS;
        end else if (c == CH_SLASH) begin
            r.emit = 1'b1;
            r.tok  = TOK_SLASH;
        end else if (c == CH_SEMI) begin
            r.emit = 1'b1;
            r.tok  = TOK_SEMI;
        end else if (c == CH_STAR) begin
            r.s.mode = S_STAR;
        end else if (etl_is_digit(c)) begin
            r.s.acc  = VALUE_BITS'(c - CH_ZERO);
            r.s.mode = S_INT;
        end else if (etl_is_head(c)) begin
            if (limit == 8'd0) begin
                r.emit   = 1'b1;
                r.tok    = TOK_LONG_IDENT;
                r.s.halt = 1'b1;
            end else begin
                r.s.kposs = (c == etl_kw_char(3'd0));
                r.s.kprog = r.s.kposs ? 3'd1 : 3'd0;
                r.s.icnt  = 8'd1;
                r.s.mode  = S_IDENT;
            end
        end else begin
            r.emit   = 1'b1;
            r.tok    = TOK_BAD_CHAR;
            r.val    = {24'd0, c};
            r.s.halt = 1'b1;
        end
        return r;
    endfunction

    logic [7:0]  r_maxlen;
    t_scan       r_scan;
    logic [31:0] r_line;

    t_result     r_buf [BUF_DEPTH];
    logic [BUF_AW-1:0] r_wp;
    logic [BUF_AW-1:0] r_rp;
    logic [BUF_AW:0]   r_cnt;

    logic        s_acc;
    logic        m_acc;
    logic [7:0]  c;
    logic [7:0]  limit;
    logic        is_word;
    logic        is_kw;
    t_step       st;
    t_scan       n_scan;
    logic [31:0] n_line;
    logic [1:0]  n_num;
    logic [3:0]  tok0;
    logic [3:0]  tok1;
    logic [31:0] val0;
    logic [31:0] val1;
    t_result     res0;
    t_result     res1;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_cnt <= (BUF_AW+1)'(BUF_DEPTH - 2));
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign m_acc       = o_m_tvalid && i_m_tready;
    assign c           = i_s_tdata;
    assign limit       = (r_maxlen != 8'd0) ? (r_maxlen - 8'd1) : 8'd0;
    assign is_word     = etl_is_head(c) || etl_is_digit(c);
    assign is_kw       = r_scan.kposs && (r_scan.kprog == KW_LEN) &&
                         (r_scan.icnt == 8'(KW_LEN));
    assign st          = f_idle(c, limit, r_scan);

    always_comb begin
        n_scan = r_scan;
        n_line = r_line;
        n_num  = 2'd0;
        tok0   = TOK_END;
        tok1   = TOK_END;
        val0   = 32'd0;
        val1   = 32'd0;
        if (s_acc && !r_scan.halt) begin
            if (i_s_tuser) begin
                n_num = 2'd1;
                case (r_scan.mode)
                    S_STAR: begin
                        tok0  = TOK_STAR;
                        n_num = 2'd2;
                    end
                    S_INT: begin
                        tok0  = TOK_INT;
                        val0  = 32'(r_scan.acc);
                        n_num = 2'd2;
                    end
                    S_IDENT: begin
                        if (is_kw) begin
                            tok0  = TOK_PRINT;
                            n_num = 2'd2;
                        end else begin
                            tok0        = TOK_BAD_IDENT;
                            n_scan.halt = 1'b1;
                        end
                    end
                    default: begin
                        tok0 = TOK_END;
                    end
                endcase
                if (!n_scan.halt) begin
                    n_scan.mode  = S_IDLE;
                    n_scan.acc   = '0;
                    n_scan.icnt  = 8'd0;
                    n_scan.kprog = 3'd0;
                    n_scan.kposs = 1'b1;
                end
            end else begin
                if (c == CH_LF) begin
                    n_line = r_line + 32'd1;
                end
                case (r_scan.mode)
                    S_STAR: begin
                        n_num = 2'd1;
                        if (c == CH_STAR) begin
                            tok0        = TOK_EXP;
                            n_scan.mode = S_IDLE;
                        end else begin
                            tok0   = TOK_STAR;
                            n_scan = st.s;
                            tok1   = st.tok;
                            val1   = st.val;
                            n_num  = st.emit ? 2'd2 : 2'd1;
                        end
                    end
                    S_INT: begin
                        if (etl_is_digit(c)) begin
                            n_scan.acc = (r_scan.acc << 3) + (r_scan.acc << 1) +
                                         VALUE_BITS'(c - CH_ZERO);
                        end else begin
                            tok0   = TOK_INT;
                            val0   = 32'(r_scan.acc);
                            n_scan = st.s;
                            tok1   = st.tok;
                            val1   = st.val;
                            n_num  = st.emit ? 2'd2 : 2'd1;
                        end
                    end
                    S_IDENT: begin
                        if (is_word) begin
                            if (r_scan.icnt >= limit) begin
                                tok0        = TOK_LONG_IDENT;
                                n_num       = 2'd1;
                                n_scan.halt = 1'b1;
                            end else begin
                                if (r_scan.kposs && (r_scan.icnt < 8'(KW_LEN)) &&
                                    (c == etl_kw_char(r_scan.icnt[2:0]))) begin
                                    n_scan.kprog = r_scan.kprog + 3'd1;
                                end else begin
                                    n_scan.kposs = 1'b0;
                                end
                                n_scan.icnt = r_scan.icnt + 8'd1;
                            end
                        end else if (is_kw) begin
                            tok0   = TOK_PRINT;
                            n_scan = st.s;
                            tok1   = st.tok;
                            val1   = st.val;
                            n_num  = st.emit ? 2'd2 : 2'd1;
                        end else begin
                            tok0        = TOK_BAD_IDENT;
                            n_num       = 2'd1;
                            n_scan.mode = S_IDLE;
                            n_scan.halt = 1'b1;
                        end
                    end
                    default: begin
                        n_scan = st.s;
                        tok0   = st.tok;
                        val0   = st.val;
                        n_num  = st.emit ? 2'd1 : 2'd0;
                    end
                endcase
            end
        end
    end

    assign res0 = '{token: tok0, value: val0, line: n_line, last: (n_num == 2'd1)};
    assign res1 = '{token: tok1, value: val1, line: n_line, last: 1'b1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maxlen <= MAX_IDENT_RST;
            r_scan   <= '{mode: S_IDLE, acc: '0, icnt: 8'd0, kprog: 3'd0,
                          kposs: 1'b1, halt: 1'b0};
            r_line   <= 32'd1;
            r_wp     <= '0;
            r_rp     <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_maxlen <= i_cfg_data;
            end
            r_scan <= n_scan;
            r_line <= n_line;
            r_wp   <= r_wp + BUF_AW'(n_num);
            if (m_acc) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (BUF_AW+1)'(n_num) - (BUF_AW+1)'(m_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_num != 2'd0) begin
            r_buf[r_wp] <= res0;
        end
        if (n_num == 2'd2) begin
            r_buf[r_wp + 1'b1] <= res1;
        end
    end

    assign o_m_tvalid = (r_cnt != '0);
    assign o_m_tdata  = {4'd0, r_buf[r_rp].line, r_buf[r_rp].value, r_buf[r_rp].token};
    assign o_m_tlast  = r_buf[r_rp].last;

    `ETL_ASSERT_NOW(a_buf_bound, 1'b1, r_cnt <= (BUF_AW+1)'(BUF_DEPTH), "result buffer overflow")
    `ETL_ASSERT_NEXT(a_halt_sticky, r_scan.halt, r_scan.halt, "halt cleared without reset")
    `ETL_ASSERT_NEXT(a_line_hold, !s_acc, $stable(r_line), "line count moved without transfer")

endmodule
